/* src/wpse_pkg.sv */
// ----------------------------------------------------------------------------
// wpse_pkg
// Shared types, constants and helpers for the pixel symbol encoder.
// ----------------------------------------------------------------------------
package wpse_pkg;

  // Default width of a pulse duration
  localparam int unsigned DurWidthDefault = 15;

  // Field widths on the ports
  localparam int unsigned ChanW  = 8;
  localparam int unsigned TicksW = 15;
  localparam int unsigned LatchW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Symbols per pixel: 24 data bits plus the closing latch symbol
  localparam int unsigned NumDataSym = 24;
  localparam logic [4:0]  LastSymIdx = 5'd24;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgBrightness = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgZeroHigh   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgZeroLow    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgOneHigh    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgOneLow     = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLatch      = 3'd5;

  // Register reset values
  localparam logic [ChanW-1:0]  BrightnessRst = 8'd50;
  localparam logic [TicksW-1:0] ZeroHighRst   = 15'd28;
  localparam logic [TicksW-1:0] ZeroLowRst    = 15'd72;
  localparam logic [TicksW-1:0] OneHighRst    = 15'd72;
  localparam logic [TicksW-1:0] OneLowRst     = 15'd28;
  localparam logic [LatchW-1:0] LatchRst      = 16'd22400;

  // Scaled pixel, green first on the wire
  typedef struct packed {
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] blue;
  } pixel_t;

  // Timing registers seen by the symbol generator
  typedef struct packed {
    logic [TicksW-1:0] zero_high;
    logic [TicksW-1:0] zero_low;
    logic [TicksW-1:0] one_high;
    logic [TicksW-1:0] one_low;
    logic [LatchW-1:0] latch;
  } timing_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic   valid;
    pixel_t data;
  } q_req_t;

  // floor(x / 255) for x up to 255*255, by reciprocal add-and-shift
  function automatic logic [ChanW-1:0] div255(input logic [2*ChanW-1:0] x);
    logic [2*ChanW:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return t[15:8];
  endfunction

endpackage

/* src/wpse_front.sv */
// ----------------------------------------------------------------------------
// wpse_front
// Accepts RGB pixels, scales each channel by brightness/255 and pushes the
// scaled pixel into the symbol queue.
// ----------------------------------------------------------------------------
module wpse_front import wpse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ChanW-1:0]   brightness_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output q_req_t             push_o,
  input  logic               push_ready_i
);

  logic                 p_valid_q, p_valid_d;
  logic [2*ChanW-1:0]   r_prod_q, g_prod_q, b_prod_q;
  logic                 accept;

  assign s_axis_tready = !p_valid_q || push_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Hold the product stage until the queue takes it
  always_comb begin
    p_valid_d = p_valid_q;
    if (accept) begin
      p_valid_d = 1'b1;
    end else if (push_ready_i) begin
      p_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
    end
  end

  // Register the channel products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_prod_q <= {8'd0, s_axis_tdata[7:0]}   * {8'd0, brightness_i};
      g_prod_q <= {8'd0, s_axis_tdata[15:8]}  * {8'd0, brightness_i};
      b_prod_q <= {8'd0, s_axis_tdata[23:16]} * {8'd0, brightness_i};
    end
  end

  // Divide by 255 and hand the pixel on
  assign push_o.valid      = p_valid_q;
  assign push_o.data.green = div255(g_prod_q);
  assign push_o.data.red   = div255(r_prod_q);
  assign push_o.data.blue  = div255(b_prod_q);

endmodule

/* src/wpse_queue.sv */
// ----------------------------------------------------------------------------
// wpse_queue
// Two-entry pixel queue between the scaling front and the symbol generator.
// ----------------------------------------------------------------------------
module wpse_queue import wpse_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  q_req_t push_i,
  output logic   push_ready_o,
  output q_req_t head_o,
  input  logic   pop_i
);

  localparam int unsigned Depth = 2;

  pixel_t       mem_q [Depth];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   count_q, count_d;
  logic         push, pop;

  assign push_ready_o = (count_q != 2'(Depth));
  assign push         = push_i.valid && push_ready_o;
  assign pop          = pop_i && (count_q != 2'd0);

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.data  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed pixel
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(Depth))
    else $error("queue occupancy above depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'(Depth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with occupancy");

endmodule

/* src/wpse_back.sv */
// ----------------------------------------------------------------------------
// wpse_back
// Walks a queued pixel one symbol per cycle while not stalled: 24 data bits,
// green first and most significant bit first, then the closing latch symbol.
// ----------------------------------------------------------------------------
module wpse_back import wpse_pkg::*; #(
  parameter int unsigned DURATION_WIDTH = DurWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  timing_t       timing_i,
  input  q_req_t        head_i,
  output logic          pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [31:0]   m_axis_tdata,   // first_ticks[14:0], second_ticks[29:15]
  output logic          m_axis_tlast,
  output logic          m_axis_tuser    // first_level
);

  localparam logic [16:0] DurMax = 17'((32'd1 << DURATION_WIDTH) - 32'd1);

  logic [4:0]        idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic [TicksW-1:0] first_q, second_q;
  logic              level_q, last_q;
  logic              load;
  logic [4:0]        bit_pos;
  logic              bit_val;
  logic [TicksW-1:0] hi_ticks, lo_ticks;
  logic [16:0]       latch_ext, latch_rem;
  logic [16:0]       latch_first, latch_second;
  logic              is_latch;

  assign load     = head_i.valid && (!out_valid_q || m_axis_tready);
  assign is_latch = (idx_q == LastSymIdx);
  assign pop_o    = load && is_latch;

  // Pick the data bit for this symbol
  assign bit_pos = 5'(NumDataSym - 1) - idx_q;
  assign bit_val = head_i.data[bit_pos];
  assign hi_ticks = (bit_val ? timing_i.one_high : timing_i.zero_high) & DurMax[TicksW-1:0];
  assign lo_ticks = (bit_val ? timing_i.one_low  : timing_i.zero_low)  & DurMax[TicksW-1:0];

  // Split a long latch gap into two segments
  always_comb begin
    latch_ext = {1'b0, timing_i.latch};
    latch_rem = latch_ext - DurMax;
    if (latch_ext > DurMax) begin
      latch_first  = DurMax;
      latch_second = (latch_rem > DurMax) ? DurMax : latch_rem;
    end else begin
      latch_first  = latch_ext;
      latch_second = 17'd0;
    end
  end

  // Advance the symbol index
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = is_latch ? 5'd0 : idx_q + 5'd1;
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      if (is_latch) begin
        level_q  <= 1'b0;
        last_q   <= 1'b1;
        first_q  <= latch_first[TicksW-1:0];
        second_q <= latch_second[TicksW-1:0];
      end else begin
        level_q  <= 1'b1;
        last_q   <= 1'b0;
        first_q  <= hi_ticks;
        second_q <= lo_ticks;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, second_q, first_q};
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = level_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastSymIdx)
    else $error("symbol index out of range");

  a_last_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> !level_q)
    else $error("closing symbol must start low");

  a_pop_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == 5'd0 && out_valid_q && last_q))
    else $error("pixel released before closing symbol");

endmodule

/* src/ws2812_pixel_symbol_encoder.sv */
// ----------------------------------------------------------------------------
// ws2812_pixel_symbol_encoder
// The first symbol of a pixel passes the product, queue and output registers.
// Throughput: 25 symbols per pixel at one symbol per cycle while the output is
// not stalled, set by the symbol generator; pixels follow back to back.
// A two-entry queue lets the scaling front keep taking pixels during stalls.
// Reset: asynchronous active low; clears the pipeline and loads the register
// defaults (brightness 50, timings 28/72/72/28, latch 22400).
// ----------------------------------------------------------------------------
module ws2812_pixel_symbol_encoder import wpse_pkg::*; #(
  parameter int unsigned DURATION_WIDTH = DurWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [23:0]         s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // first_ticks[14:0], second_ticks[29:15]
  output logic                m_axis_tlast,
  output logic                m_axis_tuser    // first_level
);

  logic [ChanW-1:0] brightness_q;
  timing_t          timing_q;
  q_req_t           push;
  logic             push_ready;
  q_req_t           head;
  logic             pop;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q       <= BrightnessRst;
      timing_q.zero_high <= ZeroHighRst;
      timing_q.zero_low  <= ZeroLowRst;
      timing_q.one_high  <= OneHighRst;
      timing_q.one_low   <= OneLowRst;
      timing_q.latch     <= LatchRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBrightness: brightness_q       <= cfg_data_i[ChanW-1:0];
        CfgZeroHigh:   timing_q.zero_high <= cfg_data_i[TicksW-1:0];
        CfgZeroLow:    timing_q.zero_low  <= cfg_data_i[TicksW-1:0];
        CfgOneHigh:    timing_q.one_high  <= cfg_data_i[TicksW-1:0];
        CfgOneLow:     timing_q.one_low   <= cfg_data_i[TicksW-1:0];
        CfgLatch:      timing_q.latch     <= cfg_data_i[LatchW-1:0];
        default: ;
      endcase
    end
  end

  wpse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .brightness_i (brightness_q),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .push_o       (push),
    .push_ready_i (push_ready)
  );

  wpse_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .head_o      (head),
    .pop_i       (pop)
  );

  wpse_back #(
    .DURATION_WIDTH(DURATION_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .timing_i     (timing_q),
    .head_i       (head),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pixel symbol encoder. Pixels go in on the
// slave stream and 25 pulse symbols per pixel come out on the master stream.
// A scoreboard predicts every symbol from the pixel and the current timing
// registers and compares each returned symbol field by field, in order.
// Registers are reloaded between phases while the encoder is drained, and
// both stream sides idle in random bursts until the last phase.
// ----------------------------------------------------------------------------
module tb;
  import wpse_pkg::*;

  // Run limits and pacing
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandPhases  = 12;
  localparam int unsigned PhaseItems  = 31;
  localparam int unsigned MaxReports  = 100;
  localparam int unsigned DurMax      = (1 << DurWidthDefault) - 1;

  // Indexes past the register file; writes there must be ignored
  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 3'd7;

  // One output symbol
  typedef struct packed {
    logic              level;
    logic [TicksW-1:0] first_ticks;
    logic [TicksW-1:0] second_ticks;
    logic              is_last;
  } symbol_t;

  // --------------------------------------------------------------------------
  // Scoreboard: register copy, symbol predictor and pending symbol queue
  // --------------------------------------------------------------------------
  class pulse_tracker;
    logic [ChanW-1:0]  brightness;
    logic [TicksW-1:0] zero_high;
    logic [TicksW-1:0] zero_low;
    logic [TicksW-1:0] one_high;
    logic [TicksW-1:0] one_low;
    logic [LatchW-1:0] latch;
    symbol_t           pending_symbols[$];
    int unsigned       errors;

    function new();
      brightness = BrightnessRst;
      zero_high  = ZeroHighRst;
      zero_low   = ZeroLowRst;
      one_high   = OneHighRst;
      one_low    = OneLowRst;
      latch      = LatchRst;
      errors     = 0;
    endfunction

    // Mirror a register write; unknown indexes leave everything alone
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgBrightness: brightness = data[ChanW-1:0];
        CfgZeroHigh:   zero_high  = data[TicksW-1:0];
        CfgZeroLow:    zero_low   = data[TicksW-1:0];
        CfgOneHigh:    one_high   = data[TicksW-1:0];
        CfgOneLow:     one_low    = data[TicksW-1:0];
        CfgLatch:      latch      = data;
        default: ;
      endcase
    endfunction

    // floor(c * brightness / 255)
    function logic [ChanW-1:0] dim(logic [ChanW-1:0] c);
      int unsigned prod;
      prod = int'(c) * int'(brightness);
      return ChanW'(prod / 255);
    endfunction

    // Queue the 25 symbols a pixel request produces
    function void note_pixel(logic [ChanW-1:0] red, logic [ChanW-1:0] green,
                             logic [ChanW-1:0] blue);
      logic [ChanW-1:0] scaled [3];
      symbol_t          sym;
      int unsigned      rest;
      scaled[0] = dim(green);
      scaled[1] = dim(red);
      scaled[2] = dim(blue);
      for (int ch = 0; ch < 3; ch++) begin
        for (int b = ChanW - 1; b >= 0; b--) begin
          sym.level        = 1'b1;
          sym.is_last      = 1'b0;
          sym.first_ticks  = TicksW'((scaled[ch][b] ? one_high : zero_high) & DurMax);
          sym.second_ticks = TicksW'((scaled[ch][b] ? one_low : zero_low) & DurMax);
          pending_symbols.push_back(sym);
        end
      end
      // Closing latch symbol; split a long latch and saturate the remainder
      sym.level   = 1'b0;
      sym.is_last = 1'b1;
      if (latch > DurMax) begin
        rest = latch - DurMax;
        if (rest > DurMax) rest = DurMax;
        sym.first_ticks  = TicksW'(DurMax);
        sym.second_ticks = TicksW'(rest);
      end else begin
        sym.first_ticks  = TicksW'(latch);
        sym.second_ticks = '0;
      end
      pending_symbols.push_back(sym);
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      end
    endfunction

    // Compare a returned symbol with the oldest pending one
    function void check_symbol(symbol_t got);
      symbol_t want;
      if (pending_symbols.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: symbol with nothing pending, expected none actual %h",
                   $time, got);
        end
        return;
      end
      want = pending_symbols.pop_front();
      if (got.level !== want.level) report("first_level", want.level, got.level);
      if (got.first_ticks !== want.first_ticks) begin
        report("first_ticks", want.first_ticks, got.first_ticks);
      end
      if (got.second_ticks !== want.second_ticks) begin
        report("second_ticks", want.second_ticks, got.second_ticks);
      end
      if (got.is_last !== want.is_last) report("last", want.is_last, got.is_last);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [31:0]         m_axis_tdata;   // first_ticks[14:0], second_ticks[29:15]
  logic                m_axis_tlast;
  logic                m_axis_tuser;   // first_level

  pulse_tracker tracker;
  bit           quiet_tail;
  int unsigned  src_gap_pct;
  int unsigned  sink_stall_pct;
  int unsigned  cycle_count;

  ws2812_pixel_symbol_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sample both handshakes; check results before noting new requests
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (m_axis_tvalid && m_axis_tready) begin
        tracker.check_symbol({m_axis_tuser, m_axis_tdata[TicksW-1:0],
                              m_axis_tdata[2*TicksW-1:TicksW], m_axis_tlast});
      end
      if (s_axis_tvalid && s_axis_tready) begin
        tracker.note_pixel(s_axis_tdata[ChanW-1:0], s_axis_tdata[2*ChanW-1:ChanW],
                           s_axis_tdata[3*ChanW-1:2*ChanW]);
      end
    end
  end

  // Output backpressure: random stall bursts
  initial begin
    int unsigned hold;
    m_axis_tready = 1'b0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (quiet_tail) begin
        m_axis_tready = 1'b1;
        hold = 0;
      end else if (hold > 0) begin
        hold--;
      end else if ($urandom_range(99) >= sink_stall_pct) begin
        m_axis_tready = 1'b1;
        hold = $urandom_range(0, 7);
      end else begin
        m_axis_tready = 1'b0;
        hold = $urandom_range(0, 18);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks; each starts and ends at a falling edge
  // --------------------------------------------------------------------------
  task automatic push_pixel(input logic [ChanW-1:0] red, input logic [ChanW-1:0] green,
                            input logic [ChanW-1:0] blue);
    if (!quiet_tail && $urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {blue, green, red};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every pending symbol, then let the pipeline empty
  task automatic settle();
    s_axis_tvalid = 1'b0;
    @(negedge clk_i);
    while (tracker.pending_symbols.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Hold write enable high; the caller drops it after the last write
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  task automatic load_timing(input logic [CfgDataW-1:0] bright, input logic [CfgDataW-1:0] zh,
                             input logic [CfgDataW-1:0] zl, input logic [CfgDataW-1:0] oh,
                             input logic [CfgDataW-1:0] ol, input logic [CfgDataW-1:0] lt);
    settle();
    cfg_write(CfgBrightness, bright);
    cfg_write(CfgZeroHigh, zh);
    cfg_write(CfgZeroLow, zl);
    cfg_write(CfgOneHigh, oh);
    cfg_write(CfgOneLow, ol);
    cfg_write(CfgLatch, lt);
    cfg_we_i = 1'b0;
  endtask

  // Register value biased toward the extremes and the latch split point
  function automatic logic [CfgDataW-1:0] reg_value(input logic [CfgIdxW-1:0] idx);
    logic [CfgDataW-1:0] top;
    case (idx)
      CfgBrightness: top = 16'h00FF;
      CfgLatch:      top = 16'hFFFF;
      default:       top = 16'h7FFF;
    endcase
    case ($urandom_range(5))
      0:       return '0;
      1:       return top;
      2:       return CfgDataW'($urandom);
      3:       return CfgDataW'($urandom_range(32766, 32769));
      default: return CfgDataW'($urandom_range(0, top));
    endcase
  endfunction

  function automatic logic [ChanW-1:0] chan_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom_range(255));
    endcase
  endfunction

  function automatic int unsigned idle_pct();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 20;
      2:       return 50;
      default: return 80;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    tracker        = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CfgBrightness;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    quiet_tail     = 1'b0;
    src_gap_pct    = 30;
    sink_stall_pct = 30;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Register defaults after reset
    push_pixel(8'd0, 8'd0, 8'd0);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd255, 8'd0, 8'd0);
    push_pixel(8'd1, 8'd128, 8'd77);

    // Full brightness, extreme bit timings, latch exactly at the largest duration
    load_timing(16'd255, 16'd0, 16'h7FFF, 16'h7FFF, 16'd0, 16'd32767);
    push_pixel(8'd255, 8'd0, 8'd0);
    push_pixel(8'd0, 8'd255, 8'd0);
    push_pixel(8'd0, 8'd0, 8'd255);
    push_pixel(8'hAA, 8'h55, 8'h0F);

    // Zero brightness, latch just past the split; unused indexes are ignored
    load_timing(16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd32768);
    cfg_write(CfgUnusedLo, 16'hFFFF);
    cfg_write(CfgUnusedHi, 16'h1234);
    cfg_we_i = 1'b0;
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd200, 8'd100, 8'd50);

    // Top data bits set on timing writes; largest latch saturates the remainder
    load_timing(16'hFF01, 16'hFFFF, 16'h8000, 16'hC003, 16'hFFFE, 16'hFFFF);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd254, 8'd128, 8'd1);

    // Zero latch
    load_timing(16'd128, 16'd350, 16'd900, 16'd900, 16'd350, 16'd0);
    push_pixel(8'd255, 8'd127, 8'd2);
    push_pixel(8'd3, 8'd64, 8'd250);

    // Near full brightness, largest latch whose remainder does not saturate
    load_timing(16'd254, 16'd12, 16'd34, 16'd56, 16'd78, 16'd65534);
    push_pixel(8'd255, 8'd255, 8'd255);
    push_pixel(8'd129, 8'd0, 8'd255);

    // Random phases with random register updates and idling levels
    for (int ph = 0; ph < RandPhases; ph++) begin
      settle();
      quiet_tail     = (ph == RandPhases - 1);
      src_gap_pct    = quiet_tail ? 0 : idle_pct();
      sink_stall_pct = quiet_tail ? 0 : idle_pct();
      for (logic [CfgIdxW-1:0] idx = CfgBrightness; idx <= CfgLatch; idx++) begin
        if ($urandom_range(9) < 6) cfg_write(idx, reg_value(idx));
      end
      if ($urandom_range(9) < 2) begin
        cfg_write($urandom_range(1) ? CfgUnusedHi : CfgUnusedLo, CfgDataW'($urandom));
      end
      cfg_we_i = 1'b0;
      for (int n = 0; n < PhaseItems; n++) begin
        push_pixel(chan_value(), chan_value(), chan_value());
      end
    end

    settle();
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/wpse_pkg.sv
src/wpse_front.sv
src/wpse_queue.sv
src/wpse_back.sv
src/ws2812_pixel_symbol_encoder.sv
tb/sv/tb.sv
